@@ rtl/core/hcr_pkg.sv @@
package hcr_pkg;

   localparam int unsigned HEIGHT_W = 24;
   localparam int unsigned COLOR_W = 8;
   localparam int unsigned CHANNELS = 3;
   localparam int unsigned T_W = 16;
   localparam int unsigned SEG_X_W = 17;
   localparam int unsigned NUMER_W = 25;
   localparam int unsigned RECIP_W = 28;
   localparam int unsigned RECIP_SHIFT = 42;
   localparam int unsigned DIV_BITS_PER_STAGE = 2;
   localparam int unsigned BAND_COUNT_DEFAULT = 14;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam int MIN_SPAN = 16;
   localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_RESET = HEIGHT_W'(0);
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET = HEIGHT_W'(16384);

   // Normalized height: 16-bit fraction where all ones means exactly 1.0.
   localparam logic [T_W-1:0] T_ONE = 16'hFFFF;
   // First fraction value of the middle (0.40) and top (0.75) gradient segments.
   localparam logic [T_W-1:0] T_MID_START = 16'd26214;
   localparam logic [T_W-1:0] T_HIGH_START = 16'd49152;

   // Per-segment denominators after cancelling common factors.
   localparam int SEG_DIV_LOW = 26214;
   localparam int SEG_DIV_MID = 91749;
   localparam int SEG_DIV_HIGH = 65535;

   // Rounded-up reciprocals; exact floor for every numerator that can occur.
   localparam longint RECIP_ONE = longint'(1) << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_LOW =
      RECIP_W'((RECIP_ONE + SEG_DIV_LOW - 1) / SEG_DIV_LOW);
   localparam logic [RECIP_W-1:0] RECIP_MID =
      RECIP_W'((RECIP_ONE + SEG_DIV_MID - 1) / SEG_DIV_MID);
   localparam logic [RECIP_W-1:0] RECIP_HIGH =
      RECIP_W'((RECIP_ONE + SEG_DIV_HIGH - 1) / SEG_DIV_HIGH);

   localparam int STOP_COLOR [4][3] = '{
      '{20, 40, 90},
      '{40, 120, 60},
      '{140, 110, 70},
      '{235, 235, 235}
   };

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } seg_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_HEIGHT,
      CSR_MAX_HEIGHT,
      CSR_CONTOUR_MODE
   } csr_index_type;

   typedef logic [CHANNELS-1:0][NUMER_W-1:0] numer_type;
   typedef logic [CHANNELS-1:0][COLOR_W-1:0] color_type;

   typedef struct packed {
      seg_type   seg;
      numer_type numer;
   } lerp_req_type;

   // Numerator a*D + (b - a)*x of one channel inside one gradient segment.
   function automatic logic [NUMER_W-1:0] seg_numer(seg_type seg, int ch,
                                                    logic [SEG_X_W-1:0] x);
      int s;
      int div;
      int base;
      int slope;
      int v;
      case (seg)
         SEG_LOW: begin
            s = 0;
            div = SEG_DIV_LOW;
         end
         SEG_MID: begin
            s = 1;
            div = SEG_DIV_MID;
         end
         default: begin
            s = 2;
            div = SEG_DIV_HIGH;
         end
      endcase
      base = STOP_COLOR[s][ch] * div;
      slope = STOP_COLOR[s + 1][ch] - STOP_COLOR[s][ch];
      v = base + slope * int'(x);
      return NUMER_W'(v);
   endfunction

   function automatic logic [RECIP_W-1:0] seg_recip(seg_type seg);
      logic [RECIP_W-1:0] m;
      case (seg)
         SEG_LOW: m = RECIP_LOW;
         SEG_MID: m = RECIP_MID;
         default: m = RECIP_HIGH;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/core/hcr_norm.sv @@
module hcr_norm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [hcr_pkg::HEIGHT_W-1:0]  in_height,
   input  logic signed [hcr_pkg::HEIGHT_W-1:0]  cfg_min,
   input  logic signed [hcr_pkg::HEIGHT_W-1:0]  cfg_max,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [hcr_pkg::T_W-1:0]              out_t
);
   import hcr_pkg::*;

   localparam int unsigned DIV_STAGES = T_W / DIV_BITS_PER_STAGE;
   localparam int unsigned WIDE_W = HEIGHT_W + 1;
   localparam int unsigned DIVIDEND_W = HEIGHT_W + T_W;
   localparam logic signed [WIDE_W-1:0] MIN_SPAN_W = WIDE_W'(MIN_SPAN);

   logic                        va_ff;
   logic signed [HEIGHT_W-1:0]  h_ff;
   logic                        vb_ff;
   logic [HEIGHT_W-1:0]         n_ff;
   logic                        lo_ff;
   logic                        hi_ff;
   logic [HEIGHT_W-1:0]         span_ff;

   // Stage 0 of these arrays forms the dividend; the others each retire
   // DIV_BITS_PER_STAGE quotient bits, shifted into the low word.
   logic [DIV_STAGES:0]         vd_ff;
   logic [HEIGHT_W-1:0]         drem_ff [DIV_STAGES+1];
   logic [T_W-1:0]              dlow_ff [DIV_STAGES+1];
   logic                        dlo_ff [DIV_STAGES+1];
   logic                        dhi_ff [DIV_STAGES+1];
   logic [HEIGHT_W-1:0]         drem_in [DIV_STAGES+1];
   logic [T_W-1:0]              dlow_in [DIV_STAGES+1];
   logic                        dlo_in [DIV_STAGES+1];
   logic                        dhi_in [DIV_STAGES+1];

   logic [DIV_STAGES:0]         rd;
   logic                        rda;
   logic                        rdb;

   logic signed [WIDE_W-1:0]    diff;
   logic signed [WIDE_W-1:0]    n_wide;
   logic [HEIGHT_W-1:0]         span_in;
   logic                        lo_in;
   logic                        hi_in;
   logic [DIVIDEND_W-1:0]       dividend;

   always_comb begin
      rd[DIV_STAGES] = out_ready || !vd_ff[DIV_STAGES];
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rd[k] = !vd_ff[k] || rd[k + 1];
      end
      rdb = !vb_ff || rd[0];
      rda = !va_ff || rdb;
   end

   assign in_ready = rda;

   always_comb begin
      diff = WIDE_W'(cfg_max) - WIDE_W'(cfg_min);
      span_in = (diff < MIN_SPAN_W) ? HEIGHT_W'(MIN_SPAN) : diff[HEIGHT_W-1:0];
      n_wide = WIDE_W'(h_ff) - WIDE_W'(cfg_min);
      lo_in = n_wide[WIDE_W-1] || (n_wide == '0);
      hi_in = !lo_in && (n_wide[HEIGHT_W-1:0] >= span_in);
   end

   // n * 65535 as n * 65536 - n.
   assign dividend = {n_ff, {T_W{1'b0}}} - {{T_W{1'b0}}, n_ff};

   always_comb begin
      logic [HEIGHT_W-1:0] r;
      logic [T_W-1:0]      l;
      logic [HEIGHT_W:0]   trial;
      drem_in[0] = dividend[DIVIDEND_W-1:T_W];
      dlow_in[0] = dividend[T_W-1:0];
      dlo_in[0] = lo_ff;
      dhi_in[0] = hi_ff;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         r = drem_ff[k - 1];
         l = dlow_ff[k - 1];
         for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            trial = {r, l[T_W-1]};
            if (trial >= {1'b0, span_ff}) begin
               trial = trial - {1'b0, span_ff};
               l = {l[T_W-2:0], 1'b1};
            end else begin
               l = {l[T_W-2:0], 1'b0};
            end
            r = trial[HEIGHT_W-1:0];
         end
         drem_in[k] = r;
         dlow_in[k] = l;
         dlo_in[k] = dlo_ff[k - 1];
         dhi_in[k] = dhi_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vd_ff <= '0;
      end else begin
         if (rda) va_ff <= in_valid;
         if (rdb) vb_ff <= va_ff;
         if (rd[0]) vd_ff[0] <= vb_ff;
         for (int k = 1; k <= DIV_STAGES; k++) begin
            if (rd[k]) vd_ff[k] <= vd_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      if (rda) h_ff <= in_height;
      if (rdb) begin
         n_ff <= n_wide[HEIGHT_W-1:0];
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      for (int k = 0; k <= DIV_STAGES; k++) begin
         if (rd[k]) begin
            drem_ff[k] <= drem_in[k];
            dlow_ff[k] <= dlow_in[k];
            dlo_ff[k] <= dlo_in[k];
            dhi_ff[k] <= dhi_in[k];
         end
      end
   end

   assign out_valid = vd_ff[DIV_STAGES];
   assign out_t = dlo_ff[DIV_STAGES] ? '0 :
                  dhi_ff[DIV_STAGES] ? T_ONE : dlow_ff[DIV_STAGES];

endmodule

@@ rtl/core/hcr_ramp.sv @@
module hcr_ramp #(
   parameter int unsigned BAND_COUNT = hcr_pkg::BAND_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [hcr_pkg::T_W-1:0] in_t,
   input  logic                  contour_mode,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hcr_pkg::lerp_req_type out_req
);
   import hcr_pkg::*;

   localparam int unsigned BAND_W = $clog2(BAND_COUNT + 1);
   localparam int unsigned PROD_W = T_W + BAND_W;

   logic                 vp_ff;
   logic [T_W-1:0]       tp_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 vq_ff;
   logic [T_W-1:0]       tq_ff;
   logic                 vr_ff;
   seg_type              seg_ff;
   logic [SEG_X_W-1:0]   x_ff;
   logic                 vs_ff;
   lerp_req_type         req_ff;

   logic                 rdp;
   logic                 rdq;
   logic                 rdr;
   logic                 rds;

   logic [T_W-1:0]       band_lut [BAND_COUNT+1];
   logic [BAND_W-1:0]    band_lo;
   logic [T_W:0]         band_rem;
   logic [BAND_W-1:0]    band;
   logic [T_W-1:0]       tq_in;
   seg_type              seg_in;
   logic [SEG_X_W-1:0]   x_in;
   lerp_req_type         req_in;

   for (genvar b = 0; b <= BAND_COUNT; b++) begin : g_band_lut
      assign band_lut[b] = T_W'((b * int'(T_ONE)) / BAND_COUNT);
   end

   assign rds = out_ready || !vs_ff;
   assign rdr = !vr_ff || rds;
   assign rdq = !vq_ff || rdr;
   assign rdp = !vp_ff || rdq;
   assign in_ready = rdp;

   // Division by 65535: x = q*65535 + (low + q), and low + q stays below 2*65535.
   always_comb begin
      band_lo = prod_ff[PROD_W-1:T_W];
      band_rem = {1'b0, prod_ff[T_W-1:0]} + (T_W + 1)'(band_lo);
      band = (band_rem >= {1'b0, T_ONE}) ? band_lo + 1'b1 : band_lo;
      tq_in = contour_mode ? band_lut[band] : tp_ff;
   end

   always_comb begin
      if (tq_ff < T_MID_START) begin
         seg_in = SEG_LOW;
         x_in = SEG_X_W'(tq_ff);
      end else if (tq_ff < T_HIGH_START) begin
         seg_in = SEG_MID;
         x_in = SEG_X_W'({tq_ff - T_MID_START, 2'b00});
      end else begin
         seg_in = SEG_HIGH;
         x_in = SEG_X_W'({tq_ff - T_HIGH_START, 2'b11});
      end
   end

   always_comb begin
      req_in.seg = seg_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         req_in.numer[c] = seg_numer(seg_ff, c, x_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vq_ff <= 1'b0;
         vr_ff <= 1'b0;
         vs_ff <= 1'b0;
      end else begin
         if (rdp) vp_ff <= in_valid;
         if (rdq) vq_ff <= vp_ff;
         if (rdr) vr_ff <= vq_ff;
         if (rds) vs_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdp) begin
         tp_ff <= in_t;
         prod_ff <= PROD_W'(in_t) * PROD_W'(BAND_COUNT);
      end
      if (rdq) tq_ff <= tq_in;
      if (rdr) begin
         seg_ff <= seg_in;
         x_ff <= x_in;
      end
      if (rds) req_ff <= req_in;
   end

   assign out_valid = vs_ff;
   assign out_req = req_ff;

endmodule

@@ rtl/core/hcr_lerp.sv @@
module hcr_lerp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hcr_pkg::lerp_req_type in_req,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hcr_pkg::color_type    out_color
);
   import hcr_pkg::*;

   localparam int unsigned MUL_W = NUMER_W + RECIP_W;
   localparam int unsigned QUOT_W = MUL_W - RECIP_SHIFT;
   localparam logic [QUOT_W-1:0] COLOR_MAX = QUOT_W'({COLOR_W{1'b1}});

   logic                  vm_ff;
   logic [QUOT_W-1:0]     quot_ff [CHANNELS];
   logic                  vo_ff;
   color_type             color_ff;

   logic                  rdm;
   logic                  rdo;
   logic [MUL_W-1:0]      mul [CHANNELS];
   logic [RECIP_W-1:0]    recip;
   color_type             color_in;

   assign rdo = out_ready || !vo_ff;
   assign rdm = !vm_ff || rdo;
   assign in_ready = rdm;

   // Multiplying by the rounded-up reciprocal gives the floor of numerator / divisor.
   always_comb begin
      recip = seg_recip(in_req.seg);
      for (int c = 0; c < CHANNELS; c++) begin
         mul[c] = MUL_W'(in_req.numer[c]) * MUL_W'(recip);
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         color_in[c] = (quot_ff[c] > COLOR_MAX) ? {COLOR_W{1'b1}} : quot_ff[c][COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdm) vm_ff <= in_valid;
         if (rdo) vo_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdm) begin
         for (int c = 0; c < CHANNELS; c++) begin
            quot_ff[c] <= mul[c][MUL_W-1:RECIP_SHIFT];
         end
      end
      if (rdo) color_ff <= color_in;
   end

   assign out_valid = vo_ff;
   assign out_color = color_ff;

endmodule

@@ rtl/core/height_to_color_ramp.sv @@
// Height to color ramp: turns each signed height sample (1/16 m) into an RGB color on a
// four-stop terrain gradient, normalized against the min_height/max_height registers and
// optionally quantized into BAND_COUNT contour bands. The block takes one item per clock
// while the output is not stalled and holds up to 17 items in flight. Most of its stages
// belong to the normalizing divider, a 16-step restoring divider that retires two quotient
// bits per pipeline stage. A stall at the output back-pressures stage by stage, so empty
// stages still take new items.
// Registers: 0 min_height and 1 max_height (24-bit signed), 2 contour_mode (bit 0).
// Write them only while no items are in flight.
module height_to_color_ramp #(
   parameter int unsigned BAND_COUNT = hcr_pkg::BAND_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,   // [23:0] height (signed)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,   // [7:0] red, [15:8] green,
                                                            // [23:16] blue
   input  logic                                csr_we,
   input  logic [hcr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hcr_pkg::HEIGHT_W-1:0]        csr_wdata
);
   import hcr_pkg::*;

   logic signed [HEIGHT_W-1:0] min_height_ff;
   logic signed [HEIGHT_W-1:0] max_height_ff;
   logic                       contour_mode_ff;

   logic                       norm_valid;
   logic                       norm_ready;
   logic [T_W-1:0]             norm_t;
   logic                       ramp_valid;
   logic                       ramp_ready;
   lerp_req_type               ramp_req;
   color_type                  color;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= MIN_HEIGHT_RESET;
         max_height_ff <= MAX_HEIGHT_RESET;
         contour_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_HEIGHT:   min_height_ff <= csr_wdata;
            CSR_MAX_HEIGHT:   max_height_ff <= csr_wdata;
            CSR_CONTOUR_MODE: contour_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   hcr_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_height (req_tdata),
      .cfg_min   (min_height_ff),
      .cfg_max   (max_height_ff),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_t     (norm_t)
   );

   hcr_ramp #(
      .BAND_COUNT (BAND_COUNT)
   ) u_ramp (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (norm_valid),
      .in_ready     (norm_ready),
      .in_t         (norm_t),
      .contour_mode (contour_mode_ff),
      .out_valid    (ramp_valid),
      .out_ready    (ramp_ready),
      .out_req      (ramp_req)
   );

   hcr_lerp u_lerp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ramp_valid),
      .in_ready  (ramp_ready),
      .in_req    (ramp_req),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_color (color)
   );

   assign rsp_tdata = color;

endmodule

@@ dv/tb_height_to_color_ramp.sv @@
`timescale 1ns / 100ps

module tb_height_to_color_ramp;
   import hcr_pkg::*;

   localparam int BANDS = 14;
   localparam longint FRAC_ONE = 65535;
   localparam longint NARROWEST_SPAN = 16;
   localparam longint HEIGHT_LOW = -8388608;
   localparam longint HEIGHT_HIGH = 8388607;
   localparam int PIPE_DRAIN = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 125;
   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int RAMP_STOPS [4][3] = '{
      '{20, 40, 90},
      '{40, 120, 60},
      '{140, 110, 70},
      '{235, 235, 235}
   };

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_t;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [HEIGHT_W-1:0] csr_wdata = '0;

   logic signed [23:0] cfg_min = 24'sd0;
   logic signed [23:0] cfg_max = 24'sd16384;
   logic cfg_contour = 1'b0;

   logic [23:0] pending_heights[$];
   rgb_t expected_colors[$];
   int heights_pushed = 0;
   int heights_taken = 0;
   int error_count = 0;
   int cycle_count = 0;
   int req_idle_max = 0;
   int rsp_idle_max = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   height_to_color_ramp #(
      .BAND_COUNT(BANDS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic rgb_t ramp_color(logic [23:0] height_raw);
      longint span;
      longint n;
      longint t;
      longint band;
      longint p;
      longint d;
      longint v;
      int s;
      int ch;
      seg_type seg;
      int chan [3];
      rgb_t c;
      span = longint'(cfg_max) - longint'(cfg_min);
      if (span < NARROWEST_SPAN) begin
         span = NARROWEST_SPAN;
      end
      n = longint'($signed(height_raw)) - longint'(cfg_min);
      if (n <= 0) begin
         t = 0;
      end else if (n >= span) begin
         t = FRAC_ONE;
      end else begin
         t = (n * FRAC_ONE) / span;
      end
      if (cfg_contour) begin
         band = (t * BANDS) / FRAC_ONE;
         t = (band * FRAC_ONE) / BANDS;
      end
      if (20 * t < 8 * FRAC_ONE) begin
         seg = SEG_LOW;
         p = 5 * t;
         d = 2 * FRAC_ONE;
      end else if (4 * t < 3 * FRAC_ONE) begin
         seg = SEG_MID;
         p = 20 * t - 8 * FRAC_ONE;
         d = 7 * FRAC_ONE;
      end else begin
         seg = SEG_HIGH;
         p = 4 * t - 3 * FRAC_ONE;
         d = FRAC_ONE;
      end
      s = int'(seg);
      for (ch = 0; ch < 3; ch++) begin
         v = (longint'(RAMP_STOPS[s][ch]) * d
              + longint'(RAMP_STOPS[s + 1][ch] - RAMP_STOPS[s][ch]) * p) / d;
         if (v < 0) begin
            v = 0;
         end
         if (v > 255) begin
            v = 255;
         end
         chan[ch] = int'(v);
      end
      c.red = chan[0][7:0];
      c.green = chan[1][7:0];
      c.blue = chan[2][7:0];
      return c;
   endfunction

   function automatic longint clamp24(longint v);
      if (v < HEIGHT_LOW) begin
         return HEIGHT_LOW;
      end
      if (v > HEIGHT_HIGH) begin
         return HEIGHT_HIGH;
      end
      return v;
   endfunction

   // Mostly heights around the configured range, with some anywhere in 24 bits.
   function automatic logic [23:0] rand_height();
      longint lo;
      longint hi;
      longint span;
      if ($urandom_range(0, 99) < 15) begin
         return 24'($urandom);
      end
      span = longint'(cfg_max) - longint'(cfg_min);
      if (span < NARROWEST_SPAN) begin
         lo = clamp24(longint'(cfg_min) - 40);
         hi = clamp24(longint'(cfg_min) + 40);
      end else begin
         lo = clamp24(longint'(cfg_min) - span / 8 - 2);
         hi = clamp24(longint'(cfg_max) + span / 8 + 2);
      end
      return 24'(lo + longint'($urandom_range(0, 32'(hi - lo))));
   endfunction

   // Accept detection and result checking.
   always @(posedge clock) begin
      rgb_t want;
      rgb_t got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_colors.push_back(ramp_color(req_tdata));
         heights_taken <= heights_taken + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red = rsp_tdata[7:0];
         got.green = rsp_tdata[15:8];
         got.blue = rsp_tdata[23:16];
         if (expected_colors.size() == 0) begin
            $error("result with no item outstanding: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_colors.pop_front();
            if (got.red !== want.red) begin
               $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
               error_count++;
            end
            if (got.green !== want.green) begin
               $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
               error_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
               error_count++;
            end
         end
      end
   end

   // Height driver.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         req_tvalid <= 1'b1;
      end else if (req_gap != 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_heights.size() != 0) begin
         req_tdata <= pending_heights.pop_front();
         req_tvalid <= 1'b1;
         req_gap <= $urandom_range(0, req_idle_max);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Color sink with random back-pressure.
   always @(negedge clock) begin
      if (rsp_fire) begin
         rsp_stall = $urandom_range(0, rsp_idle_max);
      end
      if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [HEIGHT_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_MIN_HEIGHT: cfg_min = value;
         CSR_MAX_HEIGHT: cfg_max = value;
         CSR_CONTOUR_MODE: cfg_contour = value[0];
         default: ;
      endcase
   endtask

   task automatic push_height(logic [23:0] h);
      pending_heights.push_back(h);
      heights_pushed++;
   endtask

   // Holds off until every pushed item has come back, then lets the pipe settle.
   task automatic drain();
      @(negedge clock);
      while (heights_taken != heights_pushed || expected_colors.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic pick_range(int phase);
      longint lo;
      longint hi;
      int pick;
      pick = (phase == 0) ? 0 : (phase == 1) ? 1 : $urandom_range(0, 7);
      lo = longint'($signed(24'($urandom)));
      case (pick)
         0: begin
            lo = HEIGHT_LOW;
            hi = HEIGHT_HIGH;
         end
         1: begin
            lo = HEIGHT_HIGH;
            hi = HEIGHT_LOW;
         end
         2: hi = clamp24(lo + longint'($urandom_range(0, 17)));
         3: begin
            lo = 0;
            hi = 16384;
         end
         4: hi = longint'($signed(24'($urandom)));
         5: hi = clamp24(lo + longint'($urandom_range(0, 4096)));
         6: begin
            lo = HEIGHT_HIGH;
            hi = HEIGHT_HIGH;
         end
         default: hi = clamp24(lo + longint'($urandom_range(16, 1 << 20)));
      endcase
      write_reg(CSR_MIN_HEIGHT, 24'(lo));
      write_reg(CSR_MAX_HEIGHT, 24'(hi));
   endtask

   initial begin
      logic [23:0] corner_heights [12];
      int lvl;
      corner_heights = '{24'h800000, 24'h7FFFFF, 24'd0, 24'd1, 24'd6553, 24'd6554,
                         24'd12287, 24'd12288, 24'd16383, 24'd16384, 24'h555555,
                         24'hAAAAAA};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner heights against the reset range, plain and banded.
      foreach (corner_heights[i]) push_height(corner_heights[i]);
      drain();
      write_reg(CSR_CONTOUR_MODE, 24'hABCDE1);
      write_reg(CSR_UNUSED, 24'h123456);
      foreach (corner_heights[i]) push_height(corner_heights[i]);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         pick_range(phase);
         write_reg(CSR_CONTOUR_MODE, 24'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_UNUSED, 24'($urandom));
         end
         if (phase == 0) begin
            req_idle_max = 0;
            rsp_idle_max = 0;
         end else if (phase == 1) begin
            req_idle_max = 15;
            rsp_idle_max = 15;
         end else begin
            lvl = $urandom_range(0, 2);
            req_idle_max = (lvl == 0) ? 0 : (lvl == 1) ? 3 : 15;
            lvl = $urandom_range(0, 2);
            rsp_idle_max = (lvl == 0) ? 0 : (lvl == 1) ? 3 : 15;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            push_height(rand_height());
         end
         drain();
      end

      if (error_count == 0 && expected_colors.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
